### hdl/http_body_dechunker_macros.svh
// assertion macros for the http body dechunker
// used by modules that check their own logic; needs clk and arst_n in scope
`ifndef HTTP_BODY_DECHUNKER_MACROS_SVH
`define HTTP_BODY_DECHUNKER_MACROS_SVH

// same-cycle implication
`define HBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/hbd_pkg.sv
// shared types, constants and register codes for the http body dechunker
// no dependencies
package hbd_pkg;

	localparam int CHUNK_SIZE_BITS = 24;
	localparam int REM_W           = CHUNK_SIZE_BITS + 1;
	localparam int LEN_W           = 31;
	localparam int MAX_W           = 24;
	localparam int CMP_W           = (CHUNK_SIZE_BITS > MAX_W) ? CHUNK_SIZE_BITS : MAX_W;
	localparam int CFG_DATA_W      = 31;
	localparam int CFG_IDX_W       = 2;
	localparam int PHASE_W         = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK_SIZE  = 2'd2;

	localparam logic [MAX_W-1:0] MAX_CHUNK_RESET = 24'd1048576;

	localparam logic [PHASE_W-1:0] PH_SIZE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SIZE_LF  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DATA     = 3'd2;
	localparam logic [PHASE_W-1:0] PH_TRAIL_CR = 3'd3;
	localparam logic [PHASE_W-1:0] PH_TRAIL_LF = 3'd4;

	localparam logic [7:0] CR_BYTE = 8'd13;
	localparam logic [7:0] LF_BYTE = 8'd10;
	localparam logic [REM_W-1:0] LINE_END_LEN = REM_W'(2);

	typedef struct packed {
		logic             chunk_mode;
		logic [LEN_W-1:0] expected_length;
		logic [MAX_W-1:0] max_chunk_size;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0]         phase;
		logic [CHUNK_SIZE_BITS-1:0] size_accum;
		logic [REM_W-1:0]           chunk_remaining;
		logic [LEN_W-1:0]           received_count;
		logic                       done_flag;
		logic                       error_flag;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_buffer;
	} item_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       accepted;
		logic       finished;
		logic       parse_error;
		logic       buffer_end;
	} result_t;

endpackage

### hdl/hbd_if.sv
// item channels of the http body dechunker: body bytes in, results out
// depends on nothing else
interface hbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in_buffer;

	modport source (output valid, data_byte, last_in_buffer, input ready);
	modport sink (input valid, data_byte, last_in_buffer, output ready);
endinterface

interface hbd_out_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       accepted;
	logic       finished;
	logic       parse_error;
	logic       buffer_end;

	modport source (output valid, payload_valid, payload_byte, accepted, finished,
		parse_error, buffer_end, input ready);
	modport sink (input valid, payload_valid, payload_byte, accepted, finished,
		parse_error, buffer_end, output ready);
endinterface

### hdl/http_body_dechunker.sv
// top level of the http body dechunker: input register, decode state, result register
// depends on hbd_pkg, hbd_if, hbd_cfg_regs, hbd_decode and the assertion macros
`include "http_body_dechunker_macros.svh"

// Decodes an HTTP message body one byte per item, either as a fixed length
// body or as chunked transfer coding, and gives exactly one result per byte.
// A byte is taken every cycle when the result side keeps up: throughput is one
// item per cycle, with each item held first in the input register and then in
// the result register, and the decode of size digits, line endings and
// counters done between them. body.ready follows result.ready in the same
// cycle through the two registers. The user is to write configuration on the
// wr_ port only while no item is in flight; the block does not enforce it.
module http_body_dechunker (
	input  logic                          clk,
	input  logic                          arst_n,
	hbd_in_if.sink                        body,
	hbd_out_if.source                     result,
	input  logic                          wr_en,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0] wr_data
);
	import hbd_pkg::*;

	cfg_t       cfg;
	dec_state_t st_q;
	dec_state_t st_next;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_next;
	result_t    result_q;
	logic       out_valid_q;
	logic       advance;

	hbd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	hbd_decode u_decode (
		.cfg  (cfg),
		.cur  (st_q),
		.item (item_s1),
		.nxt  (st_next),
		.res  (res_next)
	);

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign body.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			item_s1.data_byte      <= body.data_byte;
			item_s1.last_in_buffer <= body.last_in_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= PH_SIZE;
			st_q.size_accum      <= '0;
			st_q.chunk_remaining <= '0;
			st_q.received_count  <= '0;
			st_q.done_flag       <= 1'b0;
			st_q.error_flag      <= 1'b0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_next;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.payload_valid = result_q.payload_valid;
	assign result.payload_byte  = result_q.payload_byte;
	assign result.accepted      = result_q.accepted;
	assign result.finished      = result_q.finished;
	assign result.parse_error   = result_q.parse_error;
	assign result.buffer_end    = result_q.buffer_end;

	`HBD_ASSERT_NEXT(a_error_sticky, st_q.error_flag, st_q.error_flag, "error flag dropped")
	`HBD_ASSERT_NOW(a_done_excl_error, st_q.done_flag, !st_q.error_flag, "done and error both set")
	`HBD_ASSERT_NOW(a_payload_consumed, out_valid_q && result_q.payload_valid,
		result_q.accepted, "payload item not consumed")
	`HBD_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && out_valid_q && !result.ready, valid_s1,
		"item lost from input register during stall")

endmodule

### hdl/hbd_cfg_regs.sv
// configuration registers of the http body dechunker
// depends on hbd_pkg
module hbd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0] wr_data,
	output hbd_pkg::cfg_t                 cfg
);
	import hbd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunk_mode      <= 1'b0;
			cfg_q.expected_length <= '0;
			cfg_q.max_chunk_size  <= MAX_CHUNK_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHUNK_MODE: begin
					cfg_q.chunk_mode <= wr_data[0];
				end
				REG_EXPECTED_LENGTH: begin
					cfg_q.expected_length <= wr_data[LEN_W-1:0];
				end
				REG_MAX_CHUNK_SIZE: begin
					cfg_q.max_chunk_size <= wr_data[MAX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/hbd_decode.sv
// next-state and result logic for one body byte
// depends on hbd_pkg
module hbd_decode (
	input  hbd_pkg::cfg_t       cfg,
	input  hbd_pkg::dec_state_t cur,
	input  hbd_pkg::item_t      item,
	output hbd_pkg::dec_state_t nxt,
	output hbd_pkg::result_t    res
);
	import hbd_pkg::*;

	logic                       is_dec;
	logic                       is_lhex;
	logic                       is_uhex;
	logic [3:0]                 digit;
	logic                       is_hex;
	logic                       oversize;
	logic                       sat;
	logic [CHUNK_SIZE_BITS-1:0] accum_next;
	logic [LEN_W-1:0]           count_inc;
	logic [REM_W-1:0]           rem_dec;
	logic [7:0]                 b;

	assign b       = item.data_byte;
	assign is_dec  = (b >= 8'd48) && (b <= 8'd57);
	assign is_lhex = (b >= 8'd97) && (b <= 8'd102);
	assign is_uhex = (b >= 8'd65) && (b <= 8'd70);
	assign is_hex  = is_dec || is_lhex || is_uhex;

	always_comb begin
		if (is_dec) begin
			digit = 4'(b - 8'd48);
		end else if (is_lhex) begin
			digit = 4'(b - 8'd87);
		end else begin
			digit = 4'(b - 8'd55);
		end
	end

	assign oversize   = CMP_W'(cur.size_accum) >= CMP_W'(cfg.max_chunk_size);
	assign sat        = |cur.size_accum[CHUNK_SIZE_BITS-1 -: 4];
	assign accum_next = sat ? '1 : {cur.size_accum[CHUNK_SIZE_BITS-5:0], digit};
	assign count_inc  = cur.received_count + LEN_W'(1);
	assign rem_dec    = (cur.chunk_remaining != '0) ? cur.chunk_remaining - REM_W'(1)
		: cur.chunk_remaining;

	always_comb begin
		nxt = cur;
		res.payload_valid = 1'b0;
		res.accepted      = 1'b0;
		if (!cur.done_flag && !cur.error_flag) begin
			if (!cfg.chunk_mode) begin
				if (cur.received_count < cfg.expected_length) begin
					res.payload_valid  = 1'b1;
					res.accepted       = 1'b1;
					nxt.received_count = count_inc;
					if (count_inc == cfg.expected_length) begin
						nxt.done_flag = 1'b1;
					end
				end else begin
					nxt.done_flag = 1'b1;
				end
			end else begin
				case (cur.phase)
					PH_SIZE: begin
						if (oversize) begin
							nxt.error_flag = 1'b1;
						end else if (b == CR_BYTE) begin
							res.accepted = 1'b1;
							nxt.phase    = PH_SIZE_LF;
						end else if (!is_hex) begin
							nxt.error_flag = 1'b1;
						end else begin
							nxt.size_accum = accum_next;
							res.accepted   = 1'b1;
						end
					end
					PH_SIZE_LF: begin
						if (b != LF_BYTE) begin
							nxt.error_flag = 1'b1;
						end else begin
							res.accepted = 1'b1;
							if (cur.size_accum == '0) begin
								nxt.phase = PH_TRAIL_CR;
							end else begin
								nxt.chunk_remaining = REM_W'(cur.size_accum) + LINE_END_LEN;
								nxt.size_accum      = '0;
								nxt.phase           = PH_DATA;
							end
						end
					end
					PH_DATA: begin
						res.accepted        = 1'b1;
						res.payload_valid   = cur.chunk_remaining > LINE_END_LEN;
						nxt.chunk_remaining = rem_dec;
						if (rem_dec == '0) begin
							nxt.phase = PH_SIZE;
						end
					end
					PH_TRAIL_CR: begin
						if (b != CR_BYTE) begin
							nxt.error_flag = 1'b1;
						end else begin
							res.accepted = 1'b1;
							nxt.phase    = PH_TRAIL_LF;
						end
					end
					PH_TRAIL_LF: begin
						if (b != LF_BYTE) begin
							nxt.error_flag = 1'b1;
						end else begin
							res.accepted  = 1'b1;
							nxt.done_flag = 1'b1;
						end
					end
					default: begin
						nxt.error_flag = 1'b1;
					end
				endcase
			end
		end
		res.payload_byte = res.payload_valid ? b : 8'd0;
		res.finished     = nxt.done_flag;
		res.parse_error  = nxt.error_flag;
		res.buffer_end   = item.last_in_buffer;
	end

endmodule
